/* hw/rtl/pfx_pkg.sv */
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types, symbol codes and truth-table constants for the prefix
// formula tautology checker.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int WORD_W    = 32;

  // ASCII codes of the significant symbols
  localparam logic [7:0] SYM_P = 8'h70;
  localparam logic [7:0] SYM_Q = 8'h71;
  localparam logic [7:0] SYM_R = 8'h72;
  localparam logic [7:0] SYM_S = 8'h73;
  localparam logic [7:0] SYM_T = 8'h74;
  localparam logic [7:0] SYM_K = 8'h4B;
  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_N = 8'h4E;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_E = 8'h45;

  // Truth-table words: bit i is the variable's value under assignment i
  localparam logic [WORD_W-1:0] WORD_P = 32'hAAAA_AAAA;
  localparam logic [WORD_W-1:0] WORD_Q = 32'hCCCC_CCCC;
  localparam logic [WORD_W-1:0] WORD_R = 32'hF0F0_F0F0;
  localparam logic [WORD_W-1:0] WORD_S = 32'hFF00_FF00;
  localparam logic [WORD_W-1:0] WORD_T = 32'hFFFF_0000;

  typedef enum logic [2:0] {
    CODE_N    = 3'd0,
    CODE_K    = 3'd1,
    CODE_A    = 3'd2,
    CODE_C    = 3'd3,
    CODE_E    = 3'd4,
    CODE_LEFT = 3'd5
  } code_t;

  typedef struct packed {
    code_t             code;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP1,
    SH_POP2
  } shift_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EMIT
  } state_t;

  function automatic logic [WORD_W-1:0] apply_binary(code_t op, logic [WORD_W-1:0] left,
                                                     logic [WORD_W-1:0] right);
    logic [WORD_W-1:0] res;
    case (op)
      CODE_K:  res = left & right;
      CODE_A:  res = left | right;
      CODE_C:  res = ~left | right;
      default: res = ~(left ^ right);
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/prefix_formula_tautology_check.sv */
// ----------------------------------------------------------------------------
// prefix_formula_tautology_check
// Reads a prefix boolean formula one character per transfer, evaluates it
// on all 32 assignments of p..t as truth-table words and reports on the
// last character whether it is a tautology or malformed.
//
//   channel  ports                              direction
//   in       in_valid in_stall in_symbol in_last   input (in_stall out)
//   out      out_valid out_stall out_tautology     output (out_stall in)
//            out_malformed
//
// An operator or ignored character is taken in ST_IDLE. A variable then
// runs its reduction chain in ST_REDUCE (a negation pops one cell, a
// binary operator pops two) and the final push or completion. A character
// with in_last then loads the result register in ST_EMIT, waiting while
// out_stall holds a previous result. The stack is a chain of MAX_DEPTH
// shifting cells. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module prefix_formula_tautology_check
  import pfx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tautology,
  output logic       out_malformed
);

  state_t state_r, state_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [WORD_W-1:0]  value_r, value_nxt;
  logic [WORD_W-1:0]  v_r, v_nxt;
  logic complete_r, complete_nxt;
  logic error_r, error_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_taut_r, out_taut_nxt;
  logic out_bad_r, out_bad_nxt;

  shift_t shift;
  entry_t push_data;
  entry_t top;
  entry_t second;

  logic              in_xfer;
  logic              sym_sig;
  logic              sym_var;
  logic [WORD_W-1:0] sym_word;
  code_t             sym_code;
  logic              take_var;
  logic              step_done;
  logic              slot_free;
  logic              stack_full;
  logic              bad;

  pfx_stack u_stack (
    .clk       (clk),
    .shift     (shift),
    .push_data (push_data),
    .top       (top),
    .second    (second)
  );

  assign in_xfer    = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign stack_full = (depth_r == DEPTH_W'(MAX_DEPTH));
  assign bad        = error_r || !complete_r;

  // symbol decode
  always_comb begin
    sym_sig  = 1'b1;
    sym_var  = 1'b1;
    sym_word = '0;
    sym_code = CODE_N;
    case (in_symbol)
      SYM_P:   sym_word = WORD_P;
      SYM_Q:   sym_word = WORD_Q;
      SYM_R:   sym_word = WORD_R;
      SYM_S:   sym_word = WORD_S;
      SYM_T:   sym_word = WORD_T;
      SYM_N:   begin sym_var = 1'b0; sym_code = CODE_N; end
      SYM_K:   begin sym_var = 1'b0; sym_code = CODE_K; end
      SYM_A:   begin sym_var = 1'b0; sym_code = CODE_A; end
      SYM_C:   begin sym_var = 1'b0; sym_code = CODE_C; end
      SYM_E:   begin sym_var = 1'b0; sym_code = CODE_E; end
      default: sym_sig = 1'b0;
    endcase
  end

  assign take_var = sym_sig && !error_r && !complete_r && sym_var;

  // a reduction step ends the chain unless it popped a negation or a pair
  always_comb begin
    step_done = 1'b1;
    if (depth_r != '0) begin
      case (top.code)
        CODE_N:    step_done = 1'b0;
        CODE_LEFT: step_done = (depth_r < DEPTH_W'(2));
        default:   step_done = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (take_var) begin
            state_nxt = ST_REDUCE;
          end else if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_REDUCE: begin
        if (step_done) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    depth_nxt     = depth_r;
    value_nxt     = value_r;
    v_nxt         = v_r;
    complete_nxt  = complete_r;
    error_nxt     = error_r;
    last_nxt      = last_r;
    out_taut_nxt  = out_taut_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    shift         = SH_HOLD;
    push_data     = '{code: CODE_LEFT, word: v_r};
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_last;
          if (sym_sig && !error_r) begin
            if (complete_r) begin
              // trailing symbol after a complete formula
              error_nxt = 1'b1;
            end else if (sym_var) begin
              v_nxt = sym_word;
            end else if (stack_full) begin
              error_nxt = 1'b1;
            end else begin
              shift     = SH_PUSH;
              push_data = '{code: sym_code, word: '0};
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
        end
      end
      ST_REDUCE: begin
        if (depth_r == '0) begin
          value_nxt    = v_r;
          complete_nxt = 1'b1;
        end else begin
          case (top.code)
            CODE_N: begin
              v_nxt     = ~v_r;
              shift     = SH_POP1;
              depth_nxt = depth_r - DEPTH_W'(1);
            end
            CODE_LEFT: begin
              if (depth_r < DEPTH_W'(2)) begin
                error_nxt = 1'b1;
              end else begin
                v_nxt     = apply_binary(second.code, top.word, v_r);
                shift     = SH_POP2;
                depth_nxt = depth_r - DEPTH_W'(2);
              end
            end
            default: begin
              // binary operator waiting: park the left operand
              if (stack_full) begin
                error_nxt = 1'b1;
              end else begin
                shift     = SH_PUSH;
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_taut_nxt  = !bad && (value_r == '1);
          out_bad_nxt   = bad;
          depth_nxt     = '0;
          value_nxt     = '0;
          complete_nxt  = 1'b0;
          error_nxt     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      value_r     <= '0;
      complete_r  <= 1'b0;
      error_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      value_r     <= value_nxt;
      complete_r  <= complete_nxt;
      error_r     <= error_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    out_taut_r <= out_taut_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_tautology = out_taut_r;
  assign out_malformed = out_bad_r;

endmodule

/* hw/rtl/pfx_cell.sv */
// ----------------------------------------------------------------------------
// pfx_cell
// One stack cell: holds an entry and loads push_in, pop1_in or pop2_in on a push or pop.
// ----------------------------------------------------------------------------
module pfx_cell
  import pfx_pkg::*;
(
  input  logic   clk,
  input  shift_t shift,
  input  entry_t push_in,
  input  entry_t pop1_in,
  input  entry_t pop2_in,
  output entry_t entry_q
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    case (shift)
      SH_PUSH: entry_nxt = push_in;
      SH_POP1: entry_nxt = pop1_in;
      SH_POP2: entry_nxt = pop2_in;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

/* hw/rtl/pfx_stack.sv */
// ----------------------------------------------------------------------------
// pfx_stack
// Shift stack built from a row of cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module pfx_stack
  import pfx_pkg::*;
(
  input  logic   clk,
  input  shift_t shift,
  input  entry_t push_data,
  output entry_t top,
  output entry_t second
);

  entry_t cell_q [MAX_DEPTH];

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    entry_t push_src;
    entry_t pop1_src;
    entry_t pop2_src;

    if (i == 0) begin : g_head
      assign push_src = push_data;
    end else begin : g_body
      assign push_src = cell_q[i-1];
    end

    // cells at the bottom pull in filler on a pop
    if (i + 1 < MAX_DEPTH) begin : g_p1
      assign pop1_src = cell_q[i+1];
    end else begin : g_p1_end
      assign pop1_src = entry_t'('0);
    end

    if (i + 2 < MAX_DEPTH) begin : g_p2
      assign pop2_src = cell_q[i+2];
    end else begin : g_p2_end
      assign pop2_src = entry_t'('0);
    end

    pfx_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .push_in (push_src),
      .pop1_in (pop1_src),
      .pop2_in (pop2_src),
      .entry_q (cell_q[i])
    );
  end

  assign top    = cell_q[0];
  assign second = cell_q[1];

endmodule
